@@ sv/lru_block_cache_defines.svh @@
// Assertion macros shared by the cache modules.
`ifndef LRU_BLOCK_CACHE_DEFINES_SVH
`define LRU_BLOCK_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define LBC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBC_ASSERT(label, clk, rst_n, prop, msg)
`define LBC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/lbc_pkg.sv @@
package lbc_pkg;
	localparam int ENTRIES_DEF = 64;
	localparam int BLOCK_BYTES_DEF = 256;
	localparam int DISKS_DEF = 16;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_UPDATE = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_DUP = 2'd2;
	localparam logic [1:0] ST_OFF = 2'd3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_FILL = 2'd1;
	localparam logic [1:0] PH_DUP = 2'd2;
	localparam logic [1:0] PH_BAD = 2'd3;

	localparam logic [0:0] REG_ENABLE = 1'd0;
	localparam logic [0:0] REG_ENTRIES = 1'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  disk;
		logic [7:0]  block;
		logic [4:0]  word_index;
		logic [63:0] data_word;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] data_word_res;
		logic [4:0]  word_index_res;
		logic        last;
		logic [31:0] hit_count;
		logic [31:0] query_count;
	} res_t;
endpackage

@@ sv/lbc_ram.sv @@
module lbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ sv/lbc_front.sv @@
module lbc_front #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  lbc_pkg::req_t req,
	input  logic          take,
	output logic          avail,
	output lbc_pkg::req_t head
);
	localparam int AW = $clog2(DEPTH);
	lbc_pkg::req_t buf_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) buf_q[wp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (take && avail) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(take && avail);
		end
	end

	`include "lru_block_cache_defines.svh"
	`LBC_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > (AW+1)'(DEPTH), "queue overfilled")
	`LBC_ASSERT_NEVER(a_take_empty, clk, arst_n, take && !avail, "take from empty queue")
	`LBC_ASSERT(a_full_cnt, clk, arst_n, full |-> cnt_q == (AW+1)'(DEPTH), "full mismatch")
endmodule

@@ sv/lbc_back.sv @@
module lbc_back #(
	parameter int ENTRIES = 64,
	parameter int BLOCK_BYTES = 256,
	parameter int DISKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [6:0]    cfg_data,
	input  logic          avail,
	input  lbc_pkg::req_t head,
	output logic          take,
	output logic          empty,
	input  logic          pop,
	output lbc_pkg::res_t res
);
	localparam int WORDS = BLOCK_BYTES / 8;
	localparam int EW = $clog2(ENTRIES);
	localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int AW = EW + WW;
	localparam int NW = $clog2(ENTRIES + 1);
	localparam int TW = 4 + 8 + 32;
	localparam logic [31:0] CLK_MAX = 32'hFFFF_FFFF;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_ACT  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;

	logic [ENTRIES-1:0] val_q;
	logic [31:0] clk_q, hits_q, qry_q;
	logic        en_q;
	logic [6:0]  nuse_q;
	logic [1:0]  ph_q;
	logic [EW-1:0] slot_q;

	logic [2:0]  st_q;
	lbc_pkg::req_t cur_q;
	logic [EW-1:0] idx_q, idx_s1, hit_idx_q, vic_q;
	logic        scan_s1;
	logic        hit_q;
	logic [31:0] vic_st_q;
	logic [WW-1:0] w_q;
	lbc_pkg::res_t res_q;
	logic        full_q;

	logic [NW-1:0] nact;
	always_comb begin
		if (nuse_q < 7'd2) nact = NW'(2);
		else if (32'(nuse_q) > 32'(ENTRIES)) nact = NW'(ENTRIES);
		else nact = NW'(nuse_q);
	end

	logic [1:0] wph;
	logic [EW-1:0] wslot;
	logic disk_bad;
	assign disk_bad = ({4'd0, cur_q.disk} >= 8'(DISKS));
	always_comb begin
		wph = ph_q;
		wslot = slot_q;
		if (cur_q.word_index == 5'd0) begin
			if (disk_bad) wph = lbc_pkg::PH_BAD;
			else if (hit_q && cur_q.mode == lbc_pkg::MODE_INSERT) wph = lbc_pkg::PH_DUP;
			else begin
				wph = lbc_pkg::PH_FILL;
				wslot = hit_q ? hit_idx_q : vic_q;
			end
		end
	end

	logic act_go, out_go, is_write, lk_hit, alloc, res_load;
	assign act_go = (st_q == S_ACT) && (!full_q || pop);
	assign out_go = (st_q == S_OUT) && (!full_q || pop);
	assign is_write = cur_q.mode inside {lbc_pkg::MODE_INSERT, lbc_pkg::MODE_UPDATE};
	assign lk_hit = en_q && (cur_q.mode == lbc_pkg::MODE_LOOKUP) && !disk_bad && hit_q;
	assign alloc = is_write && (cur_q.word_index == 5'd0) && (wph == lbc_pkg::PH_FILL);
	assign res_load = (act_go && !lk_hit) || out_go;

	logic tag_we;
	logic [EW-1:0] tag_wa;
	logic [TW-1:0] tag_wd, tag_rd;
	logic [3:0]  rd_disk;
	logic [7:0]  rd_blk;
	logic [31:0] rd_stamp;
	assign tag_we = act_go && en_q && (lk_hit || alloc);
	assign tag_wa = lk_hit ? hit_idx_q : wslot;
	assign tag_wd = {cur_q.disk, cur_q.block, clk_q};
	assign {rd_disk, rd_blk, rd_stamp} = tag_rd;

	lbc_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_tags (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(idx_q), .rdata(tag_rd)
	);

	logic [31:0] eff_stamp;
	logic ent_match;
	assign eff_stamp = val_q[idx_s1] ? rd_stamp : 32'd0;
	assign ent_match = val_q[idx_s1] && rd_disk == cur_q.disk && rd_blk == cur_q.block;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [63:0] ram_rd;
	logic [WW-1:0] hw;
	assign hw = WW'(cur_q.word_index);
	assign ram_we = act_go && en_q && is_write && (wph == lbc_pkg::PH_FILL);
	assign ram_wa = {wslot, hw};
	assign ram_ra = {hit_idx_q, w_q};

	lbc_ram #(.WIDTH(64), .DEPTH(ENTRIES * WORDS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(cur_q.data_word),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [31:0] clk_inc, qry_inc, hits_inc;
	assign clk_inc = (clk_q != CLK_MAX) ? clk_q + 32'd1 : clk_q;
	assign qry_inc = (qry_q != CLK_MAX) ? qry_q + 32'd1 : qry_q;
	assign hits_inc = (hits_q != CLK_MAX) ? hits_q + 32'd1 : hits_q;

	lbc_pkg::res_t res_nx;
	always_comb begin
		res_nx = '0;
		res_nx.last = 1'b1;
		res_nx.hit_count = hits_q;
		res_nx.query_count = qry_q;
		if (st_q == S_OUT) begin
			res_nx.status = lbc_pkg::ST_OK;
			res_nx.data_word_res = ram_rd;
			res_nx.word_index_res = 5'(w_q);
			res_nx.last = (w_q == WW'(WORDS - 1));
		end else if (!en_q) begin
			res_nx.status = lbc_pkg::ST_OFF;
		end else if (cur_q.mode == lbc_pkg::MODE_BAD) begin
			res_nx.status = lbc_pkg::ST_MISS;
		end else if (cur_q.mode == lbc_pkg::MODE_LOOKUP) begin
			res_nx.status = lbc_pkg::ST_MISS;
			if (!disk_bad) res_nx.query_count = qry_inc;
		end else begin
			res_nx.word_index_res = cur_q.word_index;
			case (wph)
				lbc_pkg::PH_FILL: res_nx.status = lbc_pkg::ST_OK;
				lbc_pkg::PH_DUP: res_nx.status = lbc_pkg::ST_DUP;
				default: res_nx.status = lbc_pkg::ST_MISS;
			endcase
		end
	end

	assign take = (st_q == S_IDLE) && avail;
	assign empty = !full_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			clk_q <= '0;
			hits_q <= '0;
			qry_q <= '0;
			en_q <= 1'b0;
			nuse_q <= 7'd64;
			ph_q <= lbc_pkg::PH_IDLE;
			slot_q <= '0;
			st_q <= S_IDLE;
			full_q <= 1'b0;
			cur_q <= '0;
			idx_q <= '0;
			idx_s1 <= '0;
			scan_s1 <= 1'b0;
			hit_idx_q <= '0;
			vic_q <= '0;
			hit_q <= 1'b0;
			vic_st_q <= '0;
			w_q <= '0;
			res_q <= '0;
		end else begin
			if (res_load) res_q <= res_nx;
			full_q <= res_load || (full_q && !pop);
			idx_s1 <= idx_q;
			scan_s1 <= (st_q == S_SCAN);
			if (cfg_we) begin
				if (cfg_index == lbc_pkg::REG_ENABLE) begin
					en_q <= cfg_data[0];
					val_q <= '0;
					clk_q <= '0;
					slot_q <= '0;
					ph_q <= lbc_pkg::PH_IDLE;
				end else begin
					nuse_q <= cfg_data;
				end
			end else begin
				if (scan_s1) begin
					if (ent_match && !hit_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (eff_stamp < vic_st_q) begin
						vic_st_q <= eff_stamp;
						vic_q <= idx_s1;
					end
				end
				case (st_q)
					S_IDLE: begin
						if (avail) begin
							cur_q <= head;
							idx_q <= '0;
							hit_q <= 1'b0;
							hit_idx_q <= '0;
							vic_q <= '0;
							vic_st_q <= '1;
							st_q <= S_SCAN;
						end
					end
					S_SCAN: begin
						if ({1'b0, idx_q} == (EW+1)'(nact - NW'(1))) st_q <= S_WAIT;
						else idx_q <= idx_q + 1'b1;
					end
					S_WAIT: begin
						st_q <= S_ACT;
					end
					S_ACT: begin
						if (act_go) begin
							st_q <= lk_hit ? S_RD : S_IDLE;
							if (!en_q) begin
								ph_q <= lbc_pkg::PH_IDLE;
							end else if (cur_q.mode == lbc_pkg::MODE_LOOKUP) begin
								if (!disk_bad) qry_q <= qry_inc;
								if (lk_hit) begin
									clk_q <= clk_inc;
									hits_q <= hits_inc;
									w_q <= '0;
								end
							end else if (is_write) begin
								ph_q <= wph;
								slot_q <= wslot;
								if (alloc) begin
									val_q[wslot] <= 1'b1;
									clk_q <= clk_inc;
								end
							end
						end
					end
					S_RD: begin
						st_q <= S_OUT;
					end
					S_OUT: begin
						if (out_go) begin
							if (w_q == WW'(WORDS - 1)) st_q <= S_IDLE;
							else begin
								w_q <= w_q + 1'b1;
								st_q <= S_RD;
							end
						end
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

	`include "lru_block_cache_defines.svh"
	`LBC_ASSERT(a_hold, clk, arst_n, (full_q && !pop) |=> full_q, "result dropped")
	`LBC_ASSERT_NEVER(a_take_busy, clk, arst_n, take && st_q != S_IDLE, "take while busy")
	`LBC_ASSERT(a_clk_mono, clk, arst_n, !cfg_we |=> clk_q >= $past(clk_q), "use clock went back")
	`LBC_ASSERT_NEVER(a_scan_range, clk, arst_n, st_q == S_SCAN && {1'b0, idx_q} >= (EW+1)'(nact), "scan past range")
endmodule

@@ sv/lru_block_cache.sv @@
// Fully associative LRU cache of disk blocks.
// Requests enter through a queue port: a beat is taken when push is high and
// full is low. Results leave through a queue port: the oldest result is shown
// while empty is low and is taken when pop is high.
// A small request queue feeds a controller that scans the tag store one entry
// per cycle (entries_in_use, clamped to 2..64), then passes through a wait
// state and an action state that loads the result register. A lookup hit
// then returns the block word by word through read and output states, each
// word held until taken: 32 beats for a 256-byte block; every other request
// gives a single beat. Requests are served one at a time.
// Configuration writes (enable, entries in use) take effect at once and must
// be made while idle; writing the enable register clears all tags and stamps.
// Block data lives in a RAM with no reset.
// After reset the cache is disabled and every request answers "disabled".
// When the receiver stalls, the pending result holds and the controller
// waits; requests keep filling the queue until full rises.
module lru_block_cache #(
	parameter int ENTRIES = lbc_pkg::ENTRIES_DEF,
	parameter int BLOCK_BYTES = lbc_pkg::BLOCK_BYTES_DEF,
	parameter int DISKS = lbc_pkg::DISKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [6:0]    cfg_data,
	input  logic          push,
	output logic          full,
	input  lbc_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output lbc_pkg::res_t res
);
	logic avail, take;
	lbc_pkg::req_t head;

	lbc_front #(.DEPTH(4)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.take(take), .avail(avail), .head(head)
	);

	lbc_back #(.ENTRIES(ENTRIES), .BLOCK_BYTES(BLOCK_BYTES), .DISKS(DISKS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .avail(avail), .head(head), .take(take),
		.empty(empty), .pop(pop), .res(res)
	);
endmodule
